/* src/mhc_pkg.sv */
// package for the magic hash collision check unit
// shared widths, register indexes, item and result types; no dependencies
`default_nettype none

package mhc_pkg;

	localparam int TABLE_BITS_DEF = 12;
	localparam int WORD_W         = 64;
	localparam int HALF_W         = 32;
	localparam int HASH_W         = 12;
	localparam int IDX_CFG_W      = 4;
	localparam int CFG_ADDR_W     = 2;
	localparam int TOP_BYTE_LSB   = 56;
	localparam int EPOCH_BITS     = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [3:0] WEAK_LIMIT = 4'd6;
	localparam logic [IDX_CFG_W-1:0] INDEX_BITS_RST = 4'd12;

	localparam logic [CFG_ADDR_W-1:0] CFG_MAGIC      = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MASK       = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] attack;
		logic              first;
		logic              last;
		logic              is_weak;
	} mhc_item_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash_index;
		logic              collided;
		logic              magic_weak;
		logic              verdict_valid;
		logic              magic_ok;
	} mhc_result_t;

	typedef struct packed {
		logic init_busy;
	} mhc_back_status_t;

endpackage

`default_nettype wire

/* src/mhc_front.sv */
// front end: accepts an arrangement, forms the hash index and the weak check
// with one shared 32x32 multiplier over six steps; uses mhc_pkg
`default_nettype none

module mhc_front import mhc_pkg::*; #(
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       busy,
	input  wire logic [WORD_W-1:0]     occupancy,
	input  wire logic [WORD_W-1:0]     attack_set,
	input  wire logic                  first_entry,
	input  wire logic                  last_entry,
	input  wire logic [WORD_W-1:0]     magic_word,
	input  wire logic [WORD_W-1:0]     mask_word,
	input  wire logic [IDX_CFG_W-1:0]  index_bits,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [TABLE_BITS-1:0]      out_idx,
	output mhc_item_t                  out_item
);

	localparam logic [2:0] STEP_DONE = 3'd7;
	localparam logic [4:0] TB5 = 5'(TABLE_BITS);

	logic                  busy_q;
	logic [2:0]            cnt_q;
	logic [WORD_W-1:0]     occ_q;
	logic [WORD_W-1:0]     atk_q;
	logic                  first_q;
	logic                  last_q;
	logic [WORD_W-1:0]     prod_q;
	logic [WORD_W-1:0]     acc_o_q;
	logic [WORD_W-1:0]     acc_k_q;

	logic [HALF_W-1:0]     mul_a;
	logic [HALF_W-1:0]     mul_b;
	logic [4:0]            eff_bits;
	logic [4:0]            shift_amt;
	logic [TABLE_BITS-1:0] top_bits;

	always_comb begin
		unique case (cnt_q)
			3'd0: begin mul_a = occ_q[HALF_W-1:0];       mul_b = magic_word[HALF_W-1:0]; end
			3'd1: begin mul_a = occ_q[WORD_W-1:HALF_W];  mul_b = magic_word[HALF_W-1:0]; end
			3'd2: begin mul_a = occ_q[HALF_W-1:0];       mul_b = magic_word[WORD_W-1:HALF_W]; end
			3'd3: begin mul_a = mask_word[HALF_W-1:0];   mul_b = magic_word[HALF_W-1:0]; end
			3'd4: begin mul_a = mask_word[WORD_W-1:HALF_W]; mul_b = magic_word[HALF_W-1:0]; end
			3'd5: begin mul_a = mask_word[HALF_W-1:0];   mul_b = magic_word[WORD_W-1:HALF_W]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		if (index_bits == '0) begin
			eff_bits = 5'd1;
		end else if ({1'b0, index_bits} > TB5) begin
			eff_bits = TB5;
		end else begin
			eff_bits = {1'b0, index_bits};
		end
		shift_amt = TB5 - eff_bits;
		top_bits  = acc_o_q[WORD_W-1 -: TABLE_BITS];
	end

	assign busy             = busy_q;
	assign out_valid        = busy_q && (cnt_q == STEP_DONE);
	assign out_idx          = top_bits >> shift_amt;
	assign out_item.attack  = atk_q;
	assign out_item.first   = first_q;
	assign out_item.last    = last_q;
	assign out_item.is_weak = 4'($countones(acc_k_q[WORD_W-1:TOP_BYTE_LSB])) < WEAK_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (cnt_q != STEP_DONE) begin
			cnt_q <= cnt_q + 3'd1;
		end else if (out_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			occ_q   <= occupancy;
			atk_q   <= attack_set;
			first_q <= first_entry;
			last_q  <= last_entry;
		end
		if (busy_q) begin
			prod_q <= mul_a * mul_b;
			unique case (cnt_q)
				3'd1: acc_o_q <= prod_q;
				3'd2, 3'd3: acc_o_q[WORD_W-1:HALF_W] <=
					acc_o_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0];
				3'd4: acc_k_q <= prod_q;
				3'd5, 3'd6: acc_k_q[WORD_W-1:HALF_W] <=
					acc_k_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/mhc_queue.sv */
// small fifo between the front and back ends
// generic width and depth; uses mhc_pkg for defaults
`default_nettype none

module mhc_queue import mhc_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* src/mhc_back.sv */
// back end: attack table with epoch tags, sticky collision flag, result register
// clears the table after reset and on epoch wrap; uses mhc_pkg
`default_nettype none

module mhc_back import mhc_pkg::*; #(
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire logic [TABLE_BITS-1:0] q_idx,
	input  wire mhc_item_t             q_item,
	output logic                       q_pop,
	output logic                       res_empty,
	input  wire logic                  res_pop,
	output mhc_result_t                res,
	output mhc_back_status_t           status
);

	localparam int DEPTH = 1 << TABLE_BITS;
	localparam int IW    = (TABLE_BITS > HASH_W) ? TABLE_BITS : HASH_W;
	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] tag;
		logic [WORD_W-1:0]     attack;
	} entry_t;

	entry_t                mem_q [DEPTH];
	entry_t                rd_q;
	state_t                state_q;
	logic [TABLE_BITS-1:0] clr_cnt_q;
	logic                  init_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic                  flag_q;
	logic [TABLE_BITS-1:0] cur_idx_q;
	mhc_item_t             cur_q;
	mhc_result_t           res_q;
	logic                  res_valid_q;

	logic                  out_free;
	logic                  wrap;
	logic                  start;
	logic                  hit;
	logic                  do_write;
	logic                  new_flag;
	logic                  mem_we;
	logic [TABLE_BITS-1:0] mem_addr;
	entry_t                mem_wd;
	logic [IW-1:0]         idx_wide;

	always_comb begin
		out_free = !res_valid_q || res_pop;
		wrap     = (state_q == ST_IDLE) && !q_empty && q_item.first && (epoch_q == EPOCH_MAX);
		start    = (state_q == ST_IDLE) && !q_empty && out_free && !wrap;
		hit      = (rd_q.tag == epoch_q);
		do_write = (state_q == ST_EXEC) && !flag_q && !hit;
		new_flag = flag_q || (hit && (rd_q.attack != cur_q.attack));
		mem_we   = (state_q == ST_CLEAR) || do_write;
		idx_wide = IW'(cur_idx_q);
		unique case (state_q)
			ST_CLEAR: begin
				mem_addr = clr_cnt_q;
				mem_wd   = '0;
			end
			ST_EXEC: begin
				mem_addr = cur_idx_q;
				mem_wd   = '{tag: epoch_q, attack: cur_q.attack};
			end
			default: begin
				mem_addr = q_idx;
				mem_wd   = '0;
			end
		endcase
	end

	assign q_pop            = start;
	assign res_empty        = !res_valid_q;
	assign res              = res_q;
	assign status.init_busy = init_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wd;
		end
		if (start) begin
			rd_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			init_q      <= 1'b1;
			epoch_q     <= '0;
			flag_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + TABLE_BITS'(1);
					if (clr_cnt_q == '1) begin
						state_q <= ST_IDLE;
						epoch_q <= EPOCH_BITS'(1);
						init_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (wrap) begin
						state_q <= ST_CLEAR;
					end else if (start) begin
						state_q <= ST_EXEC;
						if (q_item.first) begin
							epoch_q <= epoch_q + EPOCH_BITS'(1);
							flag_q  <= 1'b0;
						end
					end
				end
				ST_EXEC: begin
					flag_q  <= new_flag;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_EXEC) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q     <= q_item;
			cur_idx_q <= q_idx;
		end
		if (state_q == ST_EXEC) begin
			res_q.hash_index    <= idx_wide[HASH_W-1:0];
			res_q.collided      <= new_flag;
			res_q.magic_weak    <= cur_q.is_weak;
			res_q.verdict_valid <= cur_q.last;
			res_q.magic_ok      <= cur_q.last && !cur_q.is_weak && !new_flag;
		end
	end

endmodule

`default_nettype wire

/* src/magic_hash_collision_check_unit.sv */
// top level of the magic hash collision check unit
// holds the configuration registers; uses mhc_pkg, mhc_front, mhc_queue, mhc_back
//
//   channel   handshake               payload
//   input     push / full             occupancy, attack_set, first_entry, last_entry
//   result    pop / empty             hash_index, collided, magic_weak,
//                                     verdict_valid, magic_ok
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// the front end holds one arrangement at a time on one shared 32x32 multiplier
// (six partial products), so a new transaction is accepted only once it has passed the last one on;
// the table read is registered, and the result register is loaded in the exec state.
// after reset the back end clears every table entry, with full held high while it does.
// the epoch tags wrap at the 255th trial after reset and every 254 trials after that;
// the table is cleared again, and full rises once the queue fills.
// a result left waiting stalls the back end, then the queue, then full; cfg_ready is always high.
`default_nettype none

module magic_hash_collision_check_unit import mhc_pkg::*; #(
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [WORD_W-1:0]     occupancy,
	input  wire logic [WORD_W-1:0]     attack_set,
	input  wire logic                  first_entry,
	input  wire logic                  last_entry,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [HASH_W-1:0]          hash_index,
	output logic                       collided,
	output logic                       magic_weak,
	output logic                       verdict_valid,
	output logic                       magic_ok,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]     cfg_data
);

	localparam int QW = TABLE_BITS + $bits(mhc_item_t);

	logic [WORD_W-1:0]     magic_q;
	logic [WORD_W-1:0]     mask_q;
	logic [IDX_CFG_W-1:0]  index_bits_q;

	logic                  front_busy;
	logic                  front_valid;
	logic [TABLE_BITS-1:0] front_idx;
	mhc_item_t             front_item;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	logic [QW-1:0]         q_rdata;
	logic [TABLE_BITS-1:0] head_idx;
	mhc_item_t             head_item;
	mhc_result_t           res;
	mhc_back_status_t      back_status;

	assign cfg_ready = 1'b1;
	assign full      = front_busy || back_status.init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q      <= '0;
			mask_q       <= '0;
			index_bits_q <= INDEX_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAGIC:      magic_q      <= cfg_data;
				CFG_MASK:       mask_q       <= cfg_data;
				CFG_INDEX_BITS: index_bits_q <= cfg_data[IDX_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	mhc_front #(
		.TABLE_BITS (TABLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (push && !full),
		.busy        (front_busy),
		.occupancy   (occupancy),
		.attack_set  (attack_set),
		.first_entry (first_entry),
		.last_entry  (last_entry),
		.magic_word  (magic_q),
		.mask_word   (mask_q),
		.index_bits  (index_bits_q),
		.out_valid   (front_valid),
		.out_ready   (!q_full),
		.out_idx     (front_idx),
		.out_item    (front_item)
	);

	mhc_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.full   (q_full),
		.wdata  ({front_idx, front_item}),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign head_idx  = q_rdata[QW-1 -: TABLE_BITS];
	assign head_item = q_rdata[$bits(mhc_item_t)-1:0];

	mhc_back #(
		.TABLE_BITS (TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_idx     (head_idx),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.res_empty (empty),
		.res_pop   (pop),
		.res       (res),
		.status    (back_status)
	);

	assign hash_index    = res.hash_index;
	assign collided      = res.collided;
	assign magic_weak    = res.magic_weak;
	assign verdict_valid = res.verdict_valid;
	assign magic_ok      = res.magic_ok;

endmodule

`default_nettype wire
